[rtl/slot_table_allocator_assert.svh]
// Assertion macros shared by the slot table allocator RTL.
// Every check is clocked on aclk and is disabled while aresetn is low.
`ifndef SLOT_TABLE_ALLOCATOR_ASSERT_SVH
`define SLOT_TABLE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLTA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slot table allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slot table allocator assertion failed");

`endif

[rtl/slta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator package
// Table sizes, command and status codes, and the types that pass between the
// entry memory, the free entry finder and the control logic.
// ----------------------------------------------------------------------------
package slta_pkg;

    localparam int ENTRIES    = 64;
    localparam int OWNER_BITS = 16;
    localparam int COUNT_BITS = 8;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Fixed widths of the beat fields.
    localparam int CMD_W      = 3;
    localparam int INDEX_W    = 6;
    localparam int OWNER_W    = 16;
    localparam int PERM_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 8;

    // Free entry search: groups of eight valid bits, then one pass over groups.
    localparam int GRP_SIZE = 8;
    localparam int GRP_BITS = 3;
    localparam int NGRP     = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INC    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEC    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [OWNER_BITS-1:0] owner;
        logic [PERM_W-1:0]     owner_perm;
        logic [PERM_W-1:0]     others_perm;
        logic [COUNT_BITS-1:0] use_count;
    } entry_t;

    typedef struct packed {
        logic              set;
        logic              clr;
        logic [ADDR_W-1:0] idx;
    } valid_upd_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] idx;
    } free_t;

endpackage

[rtl/slta_entry_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slta_entry_ram
    import slta_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/slta_free_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table free entry finder
// Holds the per-entry valid bits and finds the lowest free entry through a
// two-level tree: per-group results are registered, the group pass follows.
// ----------------------------------------------------------------------------
module slta_free_finder
    import slta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  valid_upd_t         upd,
    output logic [ENTRIES-1:0] valid_vec,
    output free_t              free
);

    logic [ENTRIES-1:0]  valid_reg;
    logic [NGRP-1:0]     grp_any_reg;
    logic [NGRP-1:0]     grp_any_next;
    logic [GRP_BITS-1:0] grp_first_reg  [NGRP];
    logic [GRP_BITS-1:0] grp_first_next [NGRP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (upd.set) begin
            valid_reg[upd.idx] <= 1'b1;
        end else if (upd.clr) begin
            valid_reg[upd.idx] <= 1'b0;
        end
    end

    // Lowest free position inside each group of eight.
    always_comb begin
        int pos;
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g]   = 1'b0;
            grp_first_next[g] = '0;
            for (int k = GRP_SIZE - 1; k >= 0; k--) begin
                pos = g * GRP_SIZE + k;
                if (pos < ENTRIES) begin
                    if (!valid_reg[ADDR_W'(pos)]) begin
                        grp_any_next[g]   = 1'b1;
                        grp_first_next[g] = GRP_BITS'(k);
                    end
                end
            end
        end
    end

    // The group stage runs every cycle; valid bits only change when a command
    // finishes, so the registered groups are current once a command executes.
    always_ff @(posedge aclk) begin
        grp_any_reg   <= grp_any_next;
        grp_first_reg <= grp_first_next;
    end

    always_comb begin
        free.found = 1'b0;
        free.idx   = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                free.found = 1'b1;
                free.idx   = ADDR_W'(g * GRP_SIZE + int'(grp_first_reg[g]));
            end
        end
    end

    assign valid_vec = valid_reg;

endmodule

[rtl/slot_table_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator
// First-fit allocator over a table of owner, permission and use-count entries.
// ----------------------------------------------------------------------------
// Usage:
// One command beat on the s_ channel produces exactly one result beat on the
// m_ channel. Create takes the lowest free entry, delete frees one, get reads
// one back, increase and decrease move its use count with saturation.
// A command is taken in the idle state (entry memory read, free search groups)
// and executed in the exec state (write back, valid update, result register
// load); no new command is taken until the previous one has executed.
// m_tvalid rises when the executing command loads the output register.
// Only one command is in flight; s_tready is high whenever none is executing.
// A finished result sits in the output register, so a new command is taken
// while it waits; if the receiver stalls, that command holds in execution
// until the output register frees up.
// Reset clears every valid bit at once, so the table is empty with no
// clearing pass; the entry memory itself is not reset.
// ----------------------------------------------------------------------------
`include "slot_table_allocator_assert.svh"

module slot_table_allocator
    import slta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], entry_index[8:3], owner_id[24:9], owner_perm[26:25],
    // others_perm[28:27], zero fill[31:29]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], result_index[7:2], owner_out[23:8], owner_perm_out[25:24],
    // others_perm_out[27:26], use_count_out[35:28], zero fill[39:36]
    output logic [39:0] m_tdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [PERM_W-1:0]  owner_perm_reg;
    logic [PERM_W-1:0]  others_perm_reg;

    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;

    logic               accept;
    logic               out_load;
    logic [ADDR_W-1:0]  addr;
    logic               idx_in_range;
    logic               entry_ok;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    valid_upd_t         upd;
    logic [ENTRIES-1:0] valid_vec;
    free_t              free;

    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  res_idx;
    logic [OWNER_W-1:0]  owner_out;
    logic [PERM_W-1:0]   owner_perm_out;
    logic [PERM_W-1:0]   others_perm_out;
    logic [COUNT_W-1:0]  use_count_out;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    slta_entry_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (ADDR_W'(s_tdata[8:3])),
        .rdata (rd_entry)
    );

    slta_free_finder u_finder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (upd),
        .valid_vec (valid_vec),
        .free      (free)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg         <= s_tdata[2:0];
            idx_reg         <= s_tdata[8:3];
            owner_reg       <= s_tdata[24:9];
            owner_perm_reg  <= s_tdata[26:25];
            others_perm_reg <= s_tdata[28:27];
        end
    end

    assign addr         = ADDR_W'(idx_reg);
    assign idx_in_range = (32'(idx_reg) < 32'(ENTRIES));
    assign entry_ok     = idx_in_range && valid_vec[addr];

    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = addr;
        wr_entry        = rd_entry;
        upd.set         = 1'b0;
        upd.clr         = 1'b0;
        upd.idx         = addr;
        status          = ST_OK;
        res_idx         = idx_reg;
        owner_out       = '0;
        owner_perm_out  = '0;
        others_perm_out = '0;
        use_count_out   = '0;

        unique case (cmd_reg)
            CMD_CREATE: begin
                if (free.found) begin
                    ram_we               = out_load;
                    ram_waddr            = free.idx;
                    wr_entry.owner       = OWNER_BITS'(owner_reg);
                    wr_entry.owner_perm  = owner_perm_reg;
                    wr_entry.others_perm = others_perm_reg;
                    wr_entry.use_count   = '0;
                    upd.set              = out_load;
                    upd.idx              = free.idx;
                    res_idx              = INDEX_W'(free.idx);
                end else begin
                    status  = ST_FULL;
                    res_idx = '0;
                end
            end
            CMD_DELETE: begin
                if (entry_ok) begin
                    upd.clr = out_load;
                end else begin
                    status = ST_BAD;
                end
            end
            CMD_GET: begin
                if (entry_ok) begin
                    owner_out       = OWNER_W'(rd_entry.owner);
                    owner_perm_out  = rd_entry.owner_perm;
                    others_perm_out = rd_entry.others_perm;
                    use_count_out   = COUNT_W'(rd_entry.use_count);
                end else begin
                    status = ST_BAD;
                end
            end
            CMD_INC: begin
                if (entry_ok) begin
                    ram_we = out_load;
                    if (rd_entry.use_count != COUNT_MAX) begin
                        wr_entry.use_count = rd_entry.use_count + 1'b1;
                    end
                end else begin
                    status = ST_BAD;
                end
            end
            CMD_DEC: begin
                if (entry_ok) begin
                    ram_we = out_load;
                    if (rd_entry.use_count != '0) begin
                        wr_entry.use_count = rd_entry.use_count - 1'b1;
                    end
                end else begin
                    status = ST_BAD;
                end
            end
            default: begin
                status = ST_BAD;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'd0, use_count_out, others_perm_out, owner_perm_out,
                            owner_out, res_idx, status};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Only one command may be in flight: the interlock keeps the memory read of
    // a new command behind the write back of the previous one.
    `SLTA_ASSERT_NEXT(a_one_in_flight, accept, !s_tready)
    `SLTA_ASSERT_SAME(a_write_only_on_finish, ram_we || upd.set || upd.clr, out_load)
    `SLTA_ASSERT_SAME(a_set_clr_exclusive, 1'b1, !(upd.set && upd.clr))
    `SLTA_ASSERT_NEXT(a_finish_loads_output, out_load, m_tvalid && s_tready)

endmodule

[tb/slot_table_allocator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator checker
// Watches the command and result channels of the slot table allocator. Each
// accepted command beat is run against a private copy of the entry table to
// work out the result it must produce, and each result beat is compared
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module slot_table_allocator_checker
    import slta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [31:0]        s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [39:0]        m_tdata,
    output int unsigned        fail_count,
    output int unsigned        awaiting,
    output logic [ENTRIES-1:0] occupied
);

    typedef struct packed {
        logic [2:0]         fill;
        logic [PERM_W-1:0]  others_perm;
        logic [PERM_W-1:0]  owner_perm;
        logic [OWNER_W-1:0] owner_id;
        logic [INDEX_W-1:0] entry_index;
        logic [CMD_W-1:0]   command;
    } command_beat_t;

    typedef struct packed {
        logic [3:0]          fill;
        logic [COUNT_W-1:0]  use_count;
        logic [PERM_W-1:0]   others_perm;
        logic [PERM_W-1:0]   owner_perm;
        logic [OWNER_W-1:0]  owner;
        logic [INDEX_W-1:0]  result_index;
        logic [STATUS_W-1:0] status;
    } result_beat_t;

    // Shadow of the entry table.
    logic [ENTRIES-1:0]    live;
    logic [OWNER_BITS-1:0] stored_owner  [ENTRIES];
    logic [PERM_W-1:0]     stored_operm  [ENTRIES];
    logic [PERM_W-1:0]     stored_xperm  [ENTRIES];
    logic [COUNT_BITS-1:0] stored_count  [ENTRIES];

    result_beat_t outstanding_results[$];
    result_beat_t oldest;
    result_beat_t seen;
    int unsigned  mismatches = 0;

    function automatic result_beat_t run_table_command(input command_beat_t cmd);
        result_beat_t r;
        int           slot;
        int           i;
        r              = '0;
        r.status       = ST_OK;
        r.result_index = cmd.entry_index;
        if (cmd.command == CMD_CREATE) begin
            slot = -1;
            for (i = 0; i < ENTRIES; i++) begin
                if (!live[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                r.status       = ST_FULL;
                r.result_index = '0;
            end else begin
                live[slot]         = 1'b1;
                stored_owner[slot] = cmd.owner_id[OWNER_BITS-1:0];
                stored_operm[slot] = cmd.owner_perm;
                stored_xperm[slot] = cmd.others_perm;
                stored_count[slot] = '0;
                r.result_index     = slot[INDEX_W-1:0];
            end
        end else if (cmd.command > CMD_DEC || int'(cmd.entry_index) >= ENTRIES ||
                     !live[cmd.entry_index]) begin
            r.status = ST_BAD;
        end else begin
            case (cmd.command)
                CMD_DELETE: begin
                    live[cmd.entry_index] = 1'b0;
                end
                CMD_GET: begin
                    r.owner       = stored_owner[cmd.entry_index];
                    r.owner_perm  = stored_operm[cmd.entry_index];
                    r.others_perm = stored_xperm[cmd.entry_index];
                    r.use_count   = stored_count[cmd.entry_index];
                end
                CMD_INC: begin
                    if (stored_count[cmd.entry_index] != COUNT_MAX)
                        stored_count[cmd.entry_index]++;
                end
                default: begin
                    if (stored_count[cmd.entry_index] != '0)
                        stored_count[cmd.entry_index]--;
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            live = '0;
            outstanding_results.delete();
        end else begin
            // The result beat always belongs to an earlier command, so it is
            // matched before this edge's command beat is predicted.
            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (outstanding_results.size() == 0) begin
                    $error("result beat with no command outstanding: %0h", m_tdata);
                    mismatches++;
                end else begin
                    oldest = outstanding_results.pop_front();
                    check_field("status", 32'(oldest.status), 32'(seen.status));
                    check_field("result_index", 32'(oldest.result_index),
                                32'(seen.result_index));
                    check_field("owner_out", 32'(oldest.owner), 32'(seen.owner));
                    check_field("owner_perm_out", 32'(oldest.owner_perm),
                                32'(seen.owner_perm));
                    check_field("others_perm_out", 32'(oldest.others_perm),
                                32'(seen.others_perm));
                    check_field("use_count_out", 32'(oldest.use_count),
                                32'(seen.use_count));
                    check_field("zero fill", 32'(oldest.fill), 32'(seen.fill));
                end
            end
            if (s_tvalid && s_tready)
                outstanding_results.push_back(run_table_command(s_tdata));
        end
        fail_count <= mismatches;
        awaiting   <= outstanding_results.size();
        occupied   <= live;
    end

endmodule

[tb/tb_slot_table_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator testbench
// Drives a directed run over every command and corner of the entry table,
// then random command sequences: table fills up to full, frees, use count
// runs to both saturation limits, reads and malformed commands. Both channels
// stall at random. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_slot_table_allocator;
    import slta_pkg::*;

    localparam int          ITEM_TARGET = 1700;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = CMD_DEC + 1'b1;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = '1;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;
    logic               quiet    = 1'b0;
    int unsigned        fail_count;
    int unsigned        awaiting;
    logic [ENTRIES-1:0] occupied;
    int unsigned        items_sent = 0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    slot_table_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slot_table_allocator_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .awaiting   (awaiting),
        .occupied   (occupied)
    );

    // Receiver: stalls at random about 13 percent of the time, never during the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic [OWNER_W-1:0] owner, input logic [PERM_W-1:0] operm,
                                input logic [PERM_W-1:0] xperm);
        if (!quiet && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, xperm, operm, owner, idx, cmd};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        quiet <= (items_sent >= 500 && items_sent < 800);
    endtask

    // Lowest-cost steering: the occupancy view lags by one command at most.
    function automatic logic [INDEX_W-1:0] pick_live_index();
        int picks[$];
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (occupied[i]) picks.push_back(i);
        end
        if (picks.size() == 0) return INDEX_W'($urandom_range(ENTRIES - 1, 0));
        return INDEX_W'(picks[$urandom_range(picks.size() - 1, 0)]);
    endfunction

    task automatic send_create();
        send_command(CMD_CREATE, INDEX_W'($urandom), OWNER_W'($urandom),
                     PERM_W'($urandom), PERM_W'($urandom));
    endtask

    initial begin
        int                 kind;
        int                 run;
        int                 n;
        logic [INDEX_W-1:0] target;
        logic [CMD_W-1:0]   op;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: free entries, first fit, reads, count floor, bad codes.
        send_command(CMD_GET,    6'd0,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_DELETE, 6'd63, 16'h0000, 2'd0, 2'd0);
        send_command(CMD_INC,    6'd5,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_DEC,    6'd5,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_CREATE, 6'd63, 16'h0000, 2'd0, 2'd0);
        send_command(CMD_CREATE, 6'd0,  16'hFFFF, 2'd3, 2'd3);
        send_command(CMD_CREATE, 6'd21, 16'hA5A5, 2'd1, 2'd2);
        send_command(CMD_GET,    6'd0,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_GET,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_DEC,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_INC,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_INC,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_GET,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_DEC,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_GET,    6'd1,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_DELETE, 6'd0,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_GET,    6'd0,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_CREATE, 6'd40, 16'h5A5A, 2'd2, 2'd1);
        send_command(CMD_GET,    6'd0,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_UNKNOWN_LO,      6'd1,  16'hFFFF, 2'd3, 2'd3);
        send_command(CMD_UNKNOWN_LO + 1'b1, 6'd63, 16'h1234, 2'd1, 2'd1);
        send_command(CMD_UNKNOWN_HI,      6'd0,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_DELETE, 6'd2,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_GET,    6'd2,  16'h0000, 2'd0, 2'd0);
        send_command(CMD_GET,    6'd63, 16'h0000, 2'd0, 2'd0);

        // Random part opens by filling the table past full and driving one
        // entry's use count into its ceiling.
        repeat (70) send_create();
        send_command(CMD_INC, 6'd1, OWNER_W'($urandom), PERM_W'($urandom),
                     PERM_W'($urandom));
        repeat (ENTRIES + 260) begin
            send_command(CMD_INC, 6'd1, OWNER_W'($urandom), PERM_W'($urandom),
                         PERM_W'($urandom));
            if ($urandom_range(31) == 0) send_command(CMD_GET, 6'd1, 16'h0, 2'd0, 2'd0);
        end
        send_command(CMD_GET, 6'd1, 16'h0000, 2'd0, 2'd0);

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(19, 0);
            if (kind < 4) begin
                // Fill run, long enough at times to reach a full table.
                run = $urandom_range(70, 4);
                repeat (run) send_create();
            end else if (kind < 7) begin
                // Free run, mostly on live entries.
                run = $urandom_range(20, 1);
                repeat (run) begin
                    target = ($urandom_range(9) == 0) ? INDEX_W'($urandom) : pick_live_index();
                    send_command(CMD_DELETE, target, OWNER_W'($urandom), PERM_W'($urandom),
                                 PERM_W'($urandom));
                end
            end else if (kind == 7) begin
                // Long increase runs on one entry, toward the ceiling.
                target = pick_live_index();
                run = $urandom_range(265, 250);
                repeat (run) begin
                    send_command(CMD_INC, target, OWNER_W'($urandom), PERM_W'($urandom),
                                 PERM_W'($urandom));
                end
                send_command(CMD_GET, target, OWNER_W'($urandom), PERM_W'($urandom),
                             PERM_W'($urandom));
            end else if (kind < 15) begin
                // Use count traffic on one entry: opens, closes and reads.
                target = pick_live_index();
                run = $urandom_range(16, 4);
                repeat (run) begin
                    n = $urandom_range(2, 0);
                    op = (n == 0) ? CMD_INC : (n == 1) ? CMD_DEC : CMD_GET;
                    send_command(op, target, OWNER_W'($urandom), PERM_W'($urandom),
                                 PERM_W'($urandom));
                end
            end else if (kind < 17) begin
                // Reads anywhere, free entries included.
                run = $urandom_range(8, 1);
                repeat (run) begin
                    send_command(CMD_GET, INDEX_W'($urandom), OWNER_W'($urandom),
                                 PERM_W'($urandom), PERM_W'($urandom));
                end
            end else begin
                // Noise: every field random, unknown command codes included.
                run = $urandom_range(10, 1);
                repeat (run) begin
                    send_command(CMD_W'($urandom_range(CMD_UNKNOWN_HI, 0)),
                                 INDEX_W'($urandom), OWNER_W'($urandom),
                                 PERM_W'($urandom), PERM_W'($urandom));
                end
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("slot_table_allocator verification clean");
        end else begin
            $display("slot_table_allocator verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("slot_table_allocator verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/slta_pkg.sv
rtl/slta_entry_ram.sv
rtl/slta_free_finder.sv
rtl/slot_table_allocator.sv
tb/slot_table_allocator_checker.sv
tb/tb_slot_table_allocator.sv
